### hdl/edv_pkg.sv
`default_nettype none
package edv_pkg;

  // Widths fixed by the field formats.
  localparam int unsigned PresW   = 32;
  localparam int unsigned VecW    = 48;
  localparam int unsigned LenW    = 31;
  localparam int unsigned OutW    = 32;
  localparam int unsigned CompW   = 16;
  localparam int unsigned CfgAddrW = 2;

  // Default and maximum number of spatial dimensions.
  localparam int unsigned MaxDimsDef = 3;
  localparam int unsigned Comps      = 3;

  // Divider: one quotient bit per stage over the 49-bit scaled difference.
  localparam int unsigned NumW     = 49;
  localparam int unsigned DivSteps = NumW;
  localparam int unsigned DivLat   = DivSteps + 1;
  localparam int unsigned LaneLat  = 5;
  localparam int unsigned RowLat   = 4;
  localparam int unsigned TotalLat = 1 + DivLat + LaneLat + RowLat;

  // Register indexes of the configuration port.
  typedef enum logic [CfgAddrW-1:0] {
    REG_DIMS  = 2'd0,
    REG_PERM0 = 2'd1,
    REG_PERM1 = 2'd2,
    REG_PERM2 = 2'd3
  } cfg_reg_e;

  localparam logic [1:0]      DimsRst  = 2'd3;
  localparam logic [VecW-1:0] Perm0Rst = 48'h0000_0000_0100;
  localparam logic [VecW-1:0] Perm1Rst = 48'h0000_0100_0000;
  localparam logic [VecW-1:0] Perm2Rst = 48'h0100_0000_0000;

  localparam logic signed [63:0] S32Max = 64'sd2147483647;
  localparam logic signed [63:0] S32Min = -64'sd2147483648;

  // Saturate a signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > S32Max) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < S32Min) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Signed component k of a packed vector.
  function automatic logic signed [CompW-1:0] comp(input logic [VecW-1:0] v,
                                                   input int unsigned k);
    return $signed(v[k*CompW +: CompW]);
  endfunction

endpackage
`default_nettype wire

### hdl/edv_in_if.sv
`default_nettype none
interface edv_in_if;
  import edv_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [PresW-1:0]  pressure_i;
  logic signed [PresW-1:0]  pressure_j;
  logic [VecW-1:0]          gradient_i;
  logic [VecW-1:0]          gradient_j;
  logic [LenW-1:0]          edge_length;
  logic [VecW-1:0]          edge_direction;
  logic [LenW-1:0]          mobility;
  modport source (output valid, pressure_i, pressure_j, gradient_i, gradient_j,
                  edge_length, edge_direction, mobility, input ready);
  modport sink (input valid, pressure_i, pressure_j, gradient_i, gradient_j,
                edge_length, edge_direction, mobility, output ready);
endinterface

interface edv_out_if;
  import edv_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OutW-1:0]  velocity_x;
  logic signed [OutW-1:0]  velocity_y;
  logic signed [OutW-1:0]  velocity_z;
  modport source (output valid, velocity_x, velocity_y, velocity_z, input ready);
  modport sink (input valid, velocity_x, velocity_y, velocity_z, output ready);
endinterface

interface edv_cfg_if;
  import edv_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CfgAddrW-1:0]  addr;
  logic [VecW-1:0]      data;
  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface
`default_nettype wire

### hdl/edge_darcy_velocity.sv
// Channel  Direction  Beat contents
// cfg_i    in         addr (register index), data (48 bits)
// in_i     in         pressures, gradients, edge length, direction, mobility
// out_o    out        velocity_x, velocity_y, velocity_z
//
// One edge enters per cycle while the pipeline is not stalled. The pipeline
// holds the pipelined divider of 49 restoring stages that forms the pressure
// difference over the edge length, followed by the lane and matrix stages.
// The whole pipeline advances together and stalls only while a result sits
// in the output register unread. Reset clears the valid pipeline and loads
// the identity permeability matrix in three dimensions.
`default_nettype none
module edge_darcy_velocity
  import edv_pkg::*;
#(
  parameter int unsigned MAX_DIMS = MaxDimsDef
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  edv_cfg_if.sink    cfg_i,
  edv_in_if.sink     in_i,
  edv_out_if.source  out_o
);

  logic [1:0]      dims_q;
  logic [VecW-1:0] perm_q [Comps];
  logic [TotalLat-1:0] vld_q;
  logic            en;
  logic            two_d;

  logic signed [PresW-1:0] pi_q, pj_q;
  logic [VecW-1:0]         gi_q, gj_q, dir_q;
  logic [LenW-1:0]         len_q, mob0_q;

  logic signed [16:0] s0 [Comps];
  logic signed [16:0] u0 [Comps];
  logic signed [16:0] s_dly_q [DivLat][Comps];
  logic signed [16:0] u_dly_q [DivLat][Comps];
  logic [LenW-1:0]    mob_dly_q [DivLat+LaneLat];
  logic signed [31:0] dp;
  logic signed [33:0] prod [Comps];
  logic signed [35:0] dot_q;
  logic signed [31:0] a [Comps];
  logic signed [OutW-1:0] vel [Comps];

  // Configuration registers.
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q    <= DimsRst;
      perm_q[0] <= Perm0Rst;
      perm_q[1] <= Perm1Rst;
      perm_q[2] <= Perm2Rst;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.addr))
        REG_DIMS:  dims_q    <= cfg_i.data[1:0];
        REG_PERM0: perm_q[0] <= cfg_i.data;
        REG_PERM1: perm_q[1] <= cfg_i.data;
        REG_PERM2: perm_q[2] <= cfg_i.data;
        default:   dims_q    <= dims_q;
      endcase
    end
  end

  assign two_d = (dims_q == 2'd2) || (MAX_DIMS < 3);

  // The pipeline moves whenever the output register is free or being read.
  assign en         = !vld_q[TotalLat-1] || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[TotalLat-2:0], in_i.valid};
    end
  end

  // Entry register.
  always_ff @(posedge clk_i) begin
    if (en) begin
      pi_q   <= in_i.pressure_i;
      pj_q   <= in_i.pressure_j;
      gi_q   <= in_i.gradient_i;
      gj_q   <= in_i.gradient_j;
      len_q  <= in_i.edge_length;
      dir_q  <= in_i.edge_direction;
      mob0_q <= in_i.mobility;
    end
  end

  // Gradient sum and negated direction; unused components are zero.
  always_comb begin
    for (int k = 0; k < Comps; k++) begin
      if (k >= MAX_DIMS || (k == 2 && two_d)) begin
        s0[k] = '0;
        u0[k] = '0;
      end else begin
        s0[k] = 17'(comp(gi_q, k)) + 17'(comp(gj_q, k));
        u0[k] = -17'(comp(dir_q, k));
      end
    end
  end

  edv_div u_div (
    .clk_i  (clk_i),
    .en_i   (en),
    .diff_i (33'(pj_q) - 33'(pi_q)),
    .len_i  (len_q),
    .quo_o  (dp)
  );

  // Side data waits alongside the divider.
  always_ff @(posedge clk_i) begin
    if (en) begin
      s_dly_q[0]   <= s0;
      u_dly_q[0]   <= u0;
      mob_dly_q[0] <= mob0_q;
      for (int d = 1; d < DivLat; d++) begin
        s_dly_q[d] <= s_dly_q[d-1];
        u_dly_q[d] <= u_dly_q[d-1];
      end
      for (int d = 1; d < DivLat + LaneLat; d++) begin
        mob_dly_q[d] <= mob_dly_q[d-1];
      end
    end
  end

  // One lane per dimension up to MAX_DIMS.
  for (genvar k = 0; k < Comps; k++) begin : g_lane
    if (k < MAX_DIMS) begin : g_on
      edv_lane u_lane (
        .clk_i  (clk_i),
        .en_i   (en),
        .s_i    (s_dly_q[DivLat-1][k]),
        .u_i    (u_dly_q[DivLat-1][k]),
        .dp_i   (dp),
        .prod_o (prod[k]),
        .dot_i  (dot_q),
        .a_o    (a[k])
      );
    end else begin : g_off
      assign prod[k] = '0;
      assign a[k]    = '0;
    end
  end

  // Merge of the lane products into the projection dot sum.
  always_ff @(posedge clk_i) begin
    if (en) begin
      dot_q <= 36'(prod[0]) + 36'(prod[1]) + 36'(prod[2]);
    end
  end

  // Matrix rows and mobility scaling.
  for (genvar i = 0; i < Comps; i++) begin : g_row
    if (i < MAX_DIMS) begin : g_on
      edv_row u_row (
        .clk_i  (clk_i),
        .en_i   (en),
        .perm_i (perm_q[i]),
        .a_i    (a),
        .mob_i  (mob_dly_q[DivLat+LaneLat-1]),
        .vel_o  (vel[i])
      );
    end else begin : g_off
      assign vel[i] = '0;
    end
  end

  assign out_o.valid      = vld_q[TotalLat-1];
  assign out_o.velocity_x = vel[0];
  assign out_o.velocity_y = vel[1];
  assign out_o.velocity_z = two_d ? '0 : vel[2];

endmodule
`default_nettype wire

### hdl/edv_div.sv
`default_nettype none
module edv_div
  import edv_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic signed [PresW:0]    diff_i,
  input  wire logic [LenW-1:0]          len_i,
  output logic signed [OutW-1:0]        quo_o
);

  logic [LenW-1:0] rem_q [DivSteps];
  logic [NumW-1:0] quo_q [DivSteps];
  logic [NumW-1:0] num_q [DivSteps];
  logic [LenW-1:0] den_q [DivSteps];
  logic            neg_q [DivSteps];

  logic [PresW:0]  mag;
  logic [NumW-1:0] num0;
  logic [LenW-1:0] den0;
  logic [NumW:0]   qs;

  // Magnitude of the scaled difference; a zero length counts as one LSB.
  assign mag  = diff_i[PresW] ? (PresW+1)'(-diff_i) : diff_i;
  assign num0 = {mag, 16'd0};
  assign den0 = (len_i == '0) ? LenW'(1) : len_i;

  // One restoring step per stage, most significant quotient bit first.
  for (genvar s = 0; s < DivSteps; s++) begin : g_step
    logic [LenW-1:0] rem_in;
    logic [NumW-1:0] quo_in;
    logic [NumW-1:0] num_in;
    logic [LenW-1:0] den_in;
    logic            neg_in;
    logic [LenW:0]   trial;
    logic            ge;
    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign quo_in = '0;
      assign num_in = num0;
      assign den_in = den0;
      assign neg_in = diff_i[PresW];
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign quo_in = quo_q[s-1];
      assign num_in = num_q[s-1];
      assign den_in = den_q[s-1];
      assign neg_in = neg_q[s-1];
    end
    assign trial = {rem_in, num_in[NumW-1-s]};
    assign ge    = trial >= {1'b0, den_in};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= ge ? LenW'(trial - {1'b0, den_in}) : trial[LenW-1:0];
        quo_q[s] <= {quo_in[NumW-2:0], ge};
        num_q[s] <= num_in;
        den_q[s] <= den_in;
        neg_q[s] <= neg_in;
      end
    end
  end

  // Apply the sign (truncation toward zero) and saturate.
  assign qs = neg_q[DivSteps-1] ? (NumW+1)'(-{1'b0, quo_q[DivSteps-1]})
                                : {1'b0, quo_q[DivSteps-1]};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quo_o <= sat32(64'($signed(qs)));
    end
  end

endmodule
`default_nettype wire

### hdl/edv_lane.sv
`default_nettype none
module edv_lane
  import edv_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                en_i,
  input  wire logic signed [16:0]  s_i,
  input  wire logic signed [16:0]  u_i,
  input  wire logic signed [31:0]  dp_i,
  output logic signed [33:0]       prod_o,
  input  wire logic signed [35:0]  dot_i,
  output logic signed [31:0]       a_o
);

  logic signed [16:0] s1_q, u1_q, s2_q, u2_q, s3_q;
  logic signed [31:0] dp1_q, dp2_q;
  logic signed [52:0] m1_q;
  logic signed [48:0] m2_q;
  logic signed [33:0] n_q;
  logic signed [35:0] f_q;
  logic signed [53:0] t;
  logic signed [54:0] tr;
  logic signed [49:0] fr;

  // Normal part at scale 2^-37, rounded to Q16.16; along part rounded from Q.30.
  assign t  = (54'(s3_q) <<< 28) - 54'(m1_q);
  assign tr = 55'(t) + 55'sd1048576;
  assign fr = 50'(m2_q) + 50'sd8192;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // Product for the dot sum, taken up by the merge.
      prod_o <= 34'(s_i) * 34'(u_i);
      s1_q   <= s_i;
      u1_q   <= u_i;
      dp1_q  <= dp_i;
      s2_q   <= s1_q;
      u2_q   <= u1_q;
      dp2_q  <= dp1_q;
      // Projection and finite-difference products.
      m1_q   <= 53'(dot_i) * 53'(u2_q);
      m2_q   <= 49'(u2_q) * 49'(dp2_q);
      s3_q   <= s2_q;
      n_q    <= 34'(tr >>> 21);
      f_q    <= 36'(fr >>> 14);
      a_o    <= sat32(64'(n_q) + 64'(f_q));
    end
  end

endmodule
`default_nettype wire

### hdl/edv_row.sv
`default_nettype none
module edv_row
  import edv_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                en_i,
  input  wire logic [VecW-1:0]     perm_i,
  input  wire logic signed [31:0]  a_i [Comps],
  input  wire logic [LenW-1:0]     mob_i,
  output logic signed [OutW-1:0]   vel_o
);

  logic signed [47:0] p_q [Comps];
  logic [LenW-1:0]    mob1_q, mob2_q;
  logic signed [31:0] w_q;
  logic signed [62:0] mw_q;
  logic signed [50:0] acc;
  logic signed [64:0] vr;

  // Row of the permeability product, rounded from Q.24.
  assign acc = 51'(p_q[0]) + 51'(p_q[1]) + 51'(p_q[2]) + 51'sd128;
  assign vr  = -65'(mw_q) + 65'sd32768;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < Comps; j++) begin
        p_q[j] <= 48'(comp(perm_i, j)) * 48'(a_i[j]);
      end
      mob1_q <= mob_i;
      w_q    <= sat32(64'(acc >>> 8));
      mob2_q <= mob1_q;
      mw_q   <= 63'($signed({1'b0, mob2_q})) * 63'(w_q);
      vel_o  <= sat32(64'(vr >>> 16));
    end
  end

endmodule
`default_nettype wire

### tb/edge_darcy_velocity_test.sv
`default_nettype none
module edge_darcy_velocity_test;
  import edv_pkg::*;

  localparam int unsigned WatchLimit = 4000;
  localparam int unsigned DrainWait  = TotalLat + 20;
  localparam int unsigned NumRandom  = 630;

  // One edge beat and one velocity beat.
  typedef struct packed {
    logic signed [31:0] p_i;
    logic signed [31:0] p_j;
    logic [VecW-1:0]    g_i;
    logic [VecW-1:0]    g_j;
    logic [LenW-1:0]    len;
    logic [VecW-1:0]    dir;
    logic [LenW-1:0]    mob;
  } edge_t;

  typedef struct packed {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
  } vel_t;

  // A row of the directed table; has_vel marks rows whose velocity is typed in.
  typedef struct {
    edge_t e;
    bit    has_vel;
    vel_t  v;
  } edge_row_t;

  logic clk_i;
  logic rst_ni;

  edv_cfg_if cfg_bus ();
  edv_in_if  edge_bus ();
  edv_out_if vel_bus ();

  edge_darcy_velocity dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus.sink),
    .in_i   (edge_bus.sink),
    .out_o  (vel_bus.source)
  );

  // Shadow copy of the configuration registers.
  logic [1:0]      dims_shadow;
  logic [VecW-1:0] perm_shadow [3];

  vel_t velocity_queue [$];
  int   mismatch_count;
  int   idle_cycles;
  bit   timed_out;
  bit   calm_phase;
  bit   hold_sink;
  int   hold_len;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Signed 16-bit lane k of a packed vector.
  function automatic longint lane16(input logic [VecW-1:0] v, input int k);
    return longint'($signed(v[16*k +: 16]));
  endfunction

  // Floor division by a power of two; arithmetic shift on 64 bits.
  function automatic longint floor_sh(input longint v, input int sh);
    return v >>> sh;
  endfunction

  function automatic longint round_sh(input longint v, input int sh);
    return floor_sh(v + (longint'(1) << (sh - 1)), sh);
  endfunction

  function automatic longint clip32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Darcy velocity of one edge under the shadow configuration.
  function automatic vel_t darcy_velocity(input edge_t e);
    int     nd;
    longint s [3];
    longint u [3];
    longint a [3];
    longint w [3];
    longint vel [3];
    longint dot, diff, len, dp, nrm, fp, acc;
    vel_t   r;
    nd = (dims_shadow == 2'd2 || MaxDimsDef < 3) ? 2 : 3;
    dot = 0;
    for (int k = 0; k < 3; k++) begin
      s[k] = 0; u[k] = 0; a[k] = 0; vel[k] = 0;
    end
    for (int k = 0; k < nd; k++) begin
      s[k] = lane16(e.g_i, k) + lane16(e.g_j, k);
      u[k] = -lane16(e.dir, k);
      dot += u[k] * s[k];
    end
    diff = longint'(e.p_j) - longint'(e.p_i);
    len = longint'(e.len);
    if (len == 0) len = 1;
    dp = clip32((diff * 65536) / len);
    for (int k = 0; k < nd; k++) begin
      nrm = round_sh(s[k] * (longint'(1) << 28) - dot * u[k], 21);
      fp = round_sh(u[k] * dp, 14);
      a[k] = clip32(nrm + fp);
    end
    for (int i = 0; i < nd; i++) begin
      acc = 0;
      for (int j = 0; j < nd; j++) acc += lane16(perm_shadow[i], j) * a[j];
      w[i] = clip32(round_sh(acc, 8));
      vel[i] = clip32(round_sh(-(longint'(e.mob) * w[i]), 16));
    end
    r.vx = vel[0][31:0];
    r.vy = vel[1][31:0];
    r.vz = vel[2][31:0];
    return r;
  endfunction

  function automatic logic [VecW-1:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // Random vector with lanes that are mostly moderate, sometimes extreme.
  function automatic logic [VecW-1:0] rand_vec();
    logic [VecW-1:0] v;
    v = rand48();
    if ($urandom_range(0, 3) != 0) begin
      for (int k = 0; k < 3; k++) v[16*k +: 16] = 16'($signed(10'($urandom)));
    end
    return v;
  endfunction

  function automatic edge_t rand_edge();
    edge_t e;
    e.p_i = $urandom;
    e.p_j = $urandom;
    if ($urandom_range(0, 2) == 0) e.p_j = e.p_i + 32'($signed(12'($urandom)));
    e.g_i = rand_vec();
    e.g_j = rand_vec();
    case ($urandom_range(0, 3))
      0: e.len = 31'($urandom);
      1: e.len = 31'($urandom_range(1, 255));
      2: e.len = 31'($urandom_range(1, 4)) << 16;
      default: e.len = 31'($urandom_range(0, 3));
    endcase
    if ($urandom_range(0, 2) == 0) begin
      e.dir = {16'h0, 16'($signed(-15'($urandom_range(0, 16384)))),
               16'($urandom_range(0, 16384))};
    end else begin
      e.dir = rand_vec();
    end
    e.mob = ($urandom_range(0, 2) == 0) ? 31'($urandom) : 31'($urandom_range(0, 1 << 17));
    return e;
  endfunction

  // Check each velocity beat against the oldest prediction.
  always @(posedge clk_i) begin
    vel_t got, want;
    if (rst_ni && vel_bus.valid && vel_bus.ready) begin
      got = '{vel_bus.velocity_x, vel_bus.velocity_y, vel_bus.velocity_z};
      if (velocity_queue.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected velocity beat %h", got);
      end else begin
        want = velocity_queue.pop_front();
        if (got.vx !== want.vx || got.vy !== want.vy || got.vz !== want.vz) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("velocity mismatch: expected x=%0d y=%0d z=%0d got x=%0d y=%0d z=%0d",
                     want.vx, want.vy, want.vz, got.vx, got.vy, got.vz);
          end
        end
      end
    end
  end

  // Watchdog on cycles with no beat on any channel.
  always @(posedge clk_i) begin
    if (!rst_ni || (edge_bus.valid && edge_bus.ready) || (vel_bus.valid && vel_bus.ready)
        || (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    @(posedge clk_i);
    wait (idle_cycles >= WatchLimit);
    timed_out = 1'b1;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Result side: random stall bursts, one long hold, none in the calm phase.
  initial begin
    int gap;
    vel_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_sink) begin
        vel_bus.ready <= 1'b0;
        repeat (hold_len) @(posedge clk_i);
        hold_sink = 1'b0;
        vel_bus.ready <= 1'b1;
      end else if (!calm_phase && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 15);
        vel_bus.ready <= 1'b0;
        repeat (gap - 1) @(posedge clk_i);
        @(posedge clk_i);
        vel_bus.ready <= 1'b1;
      end else begin
        vel_bus.ready <= 1'b1;
      end
    end
  end

  task automatic send_edge(input edge_t e, input bit idle_ok);
    if (idle_ok && !calm_phase && $urandom_range(0, 5) == 0) begin
      edge_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    edge_bus.valid          <= 1'b1;
    edge_bus.pressure_i     <= e.p_i;
    edge_bus.pressure_j     <= e.p_j;
    edge_bus.gradient_i     <= e.g_i;
    edge_bus.gradient_j     <= e.g_j;
    edge_bus.edge_length    <= e.len;
    edge_bus.edge_direction <= e.dir;
    edge_bus.mobility       <= e.mob;
    do @(posedge clk_i); while (!edge_bus.ready);
    velocity_queue.push_back(darcy_velocity(e));
  endtask

  // Writes follow each other back to back; the caller drops valid after the last one.
  task automatic write_reg(input cfg_reg_e idx, input logic [VecW-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.addr  <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk_i); while (!cfg_bus.ready);
    case (idx)
      REG_DIMS:  dims_shadow = value[1:0];
      REG_PERM0: perm_shadow[0] = value;
      REG_PERM1: perm_shadow[1] = value;
      default:   perm_shadow[2] = value;
    endcase
  endtask

  // Drain everything in flight before touching the registers.
  task automatic settle();
    edge_bus.valid <= 1'b0;
    wait (velocity_queue.size() == 0);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  initial begin
    edge_row_t table_rows [$];
    edge_row_t row;
    edge_t     e;
    mismatch_count = 0;
    idle_cycles = 0;
    timed_out = 1'b0;
    calm_phase = 1'b0;
    hold_sink = 1'b0;
    rst_ni = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.addr = REG_DIMS;
    cfg_bus.data = '0;
    edge_bus.valid = 1'b0;
    {edge_bus.pressure_i, edge_bus.pressure_j, edge_bus.gradient_i, edge_bus.gradient_j,
     edge_bus.edge_length, edge_bus.edge_direction, edge_bus.mobility} = '0;
    dims_shadow = DimsRst;
    perm_shadow[0] = Perm0Rst;
    perm_shadow[1] = Perm1Rst;
    perm_shadow[2] = Perm2Rst;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table: zero edge, saturating extremes, zero length.
    table_rows.push_back('{'{0, 0, 0, 0, 31'h10000, 0, 31'h10000}, 1'b1, '{0, 0, 0}});
    table_rows.push_back('{'{32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0, 31'd1, 48'h0000_0000_C000,
                             31'h7FFF_FFFF}, 1'b1, '{32'sh8000_0000, 0, 0}});
    table_rows.push_back('{'{5, 5, 48'hFFFF_FFFF_FFFF, 48'h7FFF_7FFF_7FFF, 31'd0,
                             48'h4000_4000_4000, 31'h10000}, 1'b0, '{0, 0, 0}});
    table_rows.push_back('{'{32'sh7FFF_FFFF, 32'sh8000_0000, 48'h8000_8000_8000,
                             48'h8000_8000_8000, 31'h7FFF_FFFF, 48'h8000_8000_8000,
                             31'h7FFF_FFFF}, 1'b0, '{0, 0, 0}});
    table_rows.push_back('{'{1, 2, 48'h0100_0200_0300, 48'h0100_FE00_0300, 31'h20000,
                             48'h0000_0000_4000, 31'h8000}, 1'b0, '{0, 0, 0}});
    table_rows.push_back('{'{0, 32'h10000, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 31'd3,
                             48'h7FFF_8000_7FFF, 31'h7FFF_FFFF}, 1'b0, '{0, 0, 0}});
    foreach (table_rows[r]) begin
      row = table_rows[r];
      send_edge(row.e, 1'b0);
      if (row.has_vel) velocity_queue[$] = row.v;
    end

    // Several register settings, each followed by random edges.
    for (int phase = 0; phase < 7; phase++) begin
      settle();
      case (phase)
        0: write_reg(REG_DIMS, 48'd2);
        1: begin
          write_reg(REG_DIMS, 48'd3);
          write_reg(REG_PERM0, 48'h7FFF_8000_7FFF);
          write_reg(REG_PERM1, 48'h8000_7FFF_8000);
          write_reg(REG_PERM2, 48'hFFFF_FFFF_FFFF);
        end
        2: begin
          write_reg(REG_DIMS, 48'd0);
          write_reg(REG_PERM0, rand48());
          write_reg(REG_PERM1, rand48());
          write_reg(REG_PERM2, rand48());
        end
        3: begin
          write_reg(REG_DIMS, 48'd1);
          write_reg(REG_PERM0, 48'h0);
          write_reg(REG_PERM1, 48'h0);
          write_reg(REG_PERM2, 48'h0);
        end
        4: begin
          write_reg(REG_DIMS, 48'd2);
          write_reg(REG_PERM0, rand48());
          write_reg(REG_PERM1, rand48());
        end
        5: begin
          write_reg(REG_DIMS, 48'hFFFF_FFFF_FFFF);
          write_reg(REG_PERM0, {3{16'h0200}});
          write_reg(REG_PERM1, {16'h0, 16'h0100, 16'h0});
          write_reg(REG_PERM2, {16'hFF00, 32'h0});
        end
        default: begin
          write_reg(REG_DIMS, 48'd3);
          calm_phase = 1'b1;
        end
      endcase
      cfg_bus.valid <= 1'b0;
      // Long receiver hold while edges keep coming, so the pipeline backs up.
      if (phase == 1) begin
        hold_len = 200;
        hold_sink = 1'b1;
      end
      for (int n = 0; n < NumRandom / 7; n++) begin
        e = rand_edge();
        send_edge(e, 1'b1);
      end
    end

    edge_bus.valid <= 1'b0;
    wait (velocity_queue.size() == 0);
    repeat (DrainWait) @(posedge clk_i);
    if (mismatch_count == 0 && !timed_out) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire
